// ===== design/imd_pkg.sv =====
// Shared types and constants for the in-band metadata deinterleaver.
`timescale 1ns / 1ps

package imd_pkg;

	// Width of the interval register and of the metadata counters
	localparam int CFG_BITS   = 32;
	localparam int COUNT_BITS = 12;
	// Length byte counts in units of 16 bytes
	localparam int UNIT_SHIFT = 4;

	// Stream phase; the two unused codes behave as payload
	typedef enum logic [1:0] {
		PH_PAYLOAD = 2'd0,
		PH_META    = 2'd1
	} phase_t;

	// One result word
	typedef struct packed {
		logic [7:0] data;
		logic       is_meta;
		logic       last;
	} res_t;

endpackage

// ===== design/icy_metadata_deinterleaver.sv =====
// In-band metadata deinterleaver: splits metadata blocks out of a byte stream.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | in_byte
//   out     | output    | out_valid/out_stall| out_byte, is_metadata, meta_last
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (meta_interval)
//
// One byte per cycle while in_stall is low: the counter compare and decrement
// sit between the input port and the result register, so a new word is taken
// every such cycle. A length byte is consumed with no output word.
// A two-entry output (result register plus skid) keeps input flowing for one more
// word under output stall; in_stall rises only while the skid entry is held.
// arst_n clears the interval, counters, phase and valid flags; cfg_ready is
// always high.
`timescale 1ns / 1ps

module icy_metadata_deinterleaver
	import imd_pkg::*;
#(
	parameter int INTERVAL_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          in_byte,
	// output stream
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                is_metadata,
	output logic                meta_last,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_BITS-1:0] cfg_data
);

	logic [CFG_BITS-1:0]      interval_q;
	logic [INTERVAL_BITS-1:0] payload_left_q, payload_left_d;
	phase_t                   phase_q, phase_d;
	logic [COUNT_BITS-1:0]    meta_length_q, meta_length_d;
	logic [COUNT_BITS-1:0]    meta_count_q, meta_count_d;
	logic [COUNT_BITS-1:0]    count_inc;
	logic [INTERVAL_BITS-1:0] reload_val;

	logic in_acc, cfg_acc, produce, pop;
	res_t res_d, out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid & ~in_stall;
	assign pop       = out_valid_q & ~out_stall;

	assign reload_val = INTERVAL_BITS'(interval_q);
	assign count_inc  = meta_count_q + COUNT_BITS'(1);

	// Interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
		end else if (cfg_acc) begin
			interval_q <= cfg_data;
		end
	end

	// Phase, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_PAYLOAD;
			payload_left_q <= '0;
			meta_length_q  <= '0;
			meta_count_q   <= '0;
		end else begin
			phase_q        <= phase_d;
			payload_left_q <= payload_left_d;
			meta_length_q  <= meta_length_d;
			meta_count_q   <= meta_count_d;
		end
	end

	// Next state and result word
	always_comb begin
		phase_d        = phase_q;
		payload_left_d = payload_left_q;
		meta_length_d  = meta_length_q;
		meta_count_d   = meta_count_q;
		produce        = 1'b0;
		res_d.data     = in_byte;
		res_d.is_meta  = 1'b0;
		res_d.last     = 1'b0;

		if (in_acc) begin
			if (interval_q == '0) begin
				// pass-through, state untouched
				produce = 1'b1;
			end else begin
				case (phase_q)
					PH_META: begin
						produce       = 1'b1;
						meta_count_d  = count_inc;
						res_d.is_meta = 1'b1;
						if (count_inc >= meta_length_q) begin
							res_d.last     = 1'b1;
							phase_d        = PH_PAYLOAD;
							payload_left_d = reload_val;
						end
					end
					default: begin
						if (payload_left_q != '0) begin
							produce        = 1'b1;
							payload_left_d = payload_left_q - INTERVAL_BITS'(1);
						end else begin
							// length byte: no result
							meta_length_d = {in_byte, {UNIT_SHIFT{1'b0}}};
							meta_count_d  = '0;
							if (in_byte == 8'd0) begin
								phase_d        = PH_PAYLOAD;
								payload_left_d = reload_val;
							end else begin
								phase_d = PH_META;
							end
						end
					end
				endcase
			end
		end

		// interval write loads the payload counter
		if (cfg_acc) begin
			payload_left_d = INTERVAL_BITS'(cfg_data);
		end
	end

	// Output register and skid entry: valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (produce) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register and skid entry: data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (produce) begin
			if (out_valid_q && !pop) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_q.data;
	assign is_metadata = out_q.is_meta;
	assign meta_last   = out_q.last;

	// Checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty result register");

	a_last_is_meta: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> out_q.is_meta)
		else $error("last flag on a payload word");

	a_meta_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_META) |-> (meta_count_q < meta_length_q))
		else $error("metadata count ran past block length");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> !skid_valid_q)
		else $error("skid entry not drained after output taken");

endmodule
